// File: rtl/b64se_pkg.sv
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
// No dependencies; compiled first.
package b64se_pkg;

    localparam int unsigned C_QUEUE_DEPTH = 2;
    localparam logic [6:0]  C_PAD_CHAR    = 7'd61;  // '='

    // Position of the incoming byte inside its three-byte group
    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } t_phase;

    // One classified byte: up to four characters, index of the last one, final flag
    typedef struct packed {
        logic [3:0][6:0] chars;
        logic [1:0]      last_idx;
        logic            fin;
    } t_job;

    // Standard alphabet A-Z a-z 0-9 + /
    function automatic logic [6:0] b64_char(input logic [5:0] six);
        logic [6:0] v;
        v = {1'b0, six};
        if (six < 6'd26) begin
            b64_char = 7'd65 + v;
        end else if (six < 6'd52) begin
            b64_char = 7'd71 + v;          // 'a' - 26
        end else if (six < 6'd62) begin
            b64_char = v - 7'd4;           // '0' - 52
        end else if (six == 6'd62) begin
            b64_char = 7'd43;              // '+'
        end else begin
            b64_char = 7'd47;              // '/'
        end
    endfunction

endpackage

// File: rtl/b64se_if.sv
// Valid/ready channel interfaces for the byte input and the character output.
// No dependencies.
interface b64se_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_final;

    modport source (output valid, output data_byte, output is_final, input ready);
    modport sink   (input valid, input data_byte, input is_final, output ready);
endinterface

interface b64se_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       run_last;
    logic       message_last;

    modport source (output valid, output out_char, output run_last, output message_last,
                    input ready);
    modport sink   (input valid, input out_char, input run_last, input message_last,
                    output ready);
endinterface

// File: rtl/b64se_front.sv
// Front end: accepts bytes, tracks group phase and carry bits, builds character jobs.
// Depends on b64se_pkg and b64se_in_if.
module b64se_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    b64se_in_if.sink          i_in,
    input  logic              i_full,
    output logic              o_push,
    output b64se_pkg::t_job   o_job
);
    import b64se_pkg::*;

    t_phase     r_phase, n_phase;
    logic [3:0] r_carry, n_carry;
    logic [5:0] c0, c1;
    logic [7:0] b;
    logic       fin;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;
    assign b          = i_in.data_byte;
    assign fin        = i_in.is_final;

    always_comb begin
        c0      = b[7:2];
        c1      = {b[1:0], 4'd0};
        n_phase = PH_1;
        n_carry = {2'd0, b[1:0]};
        o_job.last_idx = fin ? 2'd3 : 2'd0;
        unique case (r_phase)
            PH_1: begin
                c0      = {r_carry[1:0], b[7:4]};
                c1      = {b[3:0], 2'd0};
                n_phase = PH_2;
                n_carry = b[3:0];
                o_job.last_idx = fin ? 2'd2 : 2'd0;
            end
            PH_2: begin
                c0      = {r_carry, b[7:6]};
                c1      = b[5:0];
                n_phase = PH_0;
                n_carry = 4'd0;
                o_job.last_idx = 2'd1;
            end
            default: begin
                // start of group; the unused code behaves the same
            end
        endcase
        if (fin) begin
            n_phase = PH_0;
            n_carry = 4'd0;
        end
        o_job.chars[0] = b64_char(c0);
        o_job.chars[1] = b64_char(c1);
        o_job.chars[2] = C_PAD_CHAR;
        o_job.chars[3] = C_PAD_CHAR;
        o_job.fin      = fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_0;
            r_carry <= 4'd0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

endmodule

// File: rtl/b64se_queue.sv
// Short job queue between front and back ends, show-ahead read.
// Depends on b64se_pkg.
module b64se_queue #(
    parameter int unsigned Depth = b64se_pkg::C_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64se_pkg::t_job   i_job,
    output logic              o_full,
    output logic              o_valid,
    output b64se_pkg::t_job   o_job,
    input  logic              i_pop
);
    import b64se_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    t_job            r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/b64se_back.sv
// Back end: plays out one job a character per beat from a registered job slot.
// Depends on b64se_pkg and b64se_out_if.
module b64se_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  b64se_pkg::t_job   i_job,
    output logic              o_pop,
    b64se_out_if.source       o_out
);
    import b64se_pkg::*;

    t_job       r_job;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       is_last, out_fire, load;

    assign is_last  = (r_idx == r_job.last_idx);
    assign out_fire = r_busy && o_out.ready;
    assign load     = !r_busy || (out_fire && is_last);
    assign o_pop    = load && i_valid;

    assign o_out.valid        = r_busy;
    assign o_out.out_char     = r_job.chars[r_idx];
    assign o_out.run_last     = is_last;
    assign o_out.message_last = is_last && r_job.fin;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (out_fire) begin
            if (is_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

// File: rtl/base64_stream_encoder_top.sv
// Streaming base64 encoder: one byte in per beat, one ASCII character out per beat.
// An accepted byte is registered as a job in the queue, then in the back end job slot.
// Throughput: one character per cycle while o_out.ready is high; a byte yields 1 to 4
// characters (four per three bytes in steady runs).
// The single-character output port of the back end sets that rate.
// Reset (i_rst_n low, synchronous): group phase and carry cleared, queue and output emptied.
module base64_stream_encoder_top #(
    parameter int unsigned QueueDepth = b64se_pkg::C_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    b64se_in_if.sink      i_in,
    b64se_out_if.source   o_out
);
    import b64se_pkg::*;

    // Front end -> queue
    logic q_push;
    logic q_full;
    t_job front_job;

    // Queue -> back end
    logic q_valid;
    logic q_pop;
    t_job q_job;

    // Front end: keeps the group phase and the leftover bits of the previous
    // byte, and turns each byte into a job of up to four characters with
    // padding already filled in for a final byte.
    b64se_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_job   (front_job)
    );

    // Short queue lets the front keep taking bytes while the back end is still
    // playing out the characters of earlier ones.
    b64se_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    // Back end: holds one job in registers and hands out a character per
    // beat; on the last beat of a job the next one, if queued, loads in the same cycle.
    b64se_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule
